[sv/ipt_pkg.sv]
// ---------------------------------------------------------------------------
// ipt_pkg - shared types and helpers for the interval pump timer
// Item and result layouts, timing constants, knob scaling functions.
// ---------------------------------------------------------------------------
package ipt_pkg;

  // default parameter values
  localparam int TICKS_PER_SECOND_DEF = 10;
  localparam int SECONDS_WIDTH_DEF    = 20;

  // input kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  // knob level range and timing
  localparam int          LEVEL_W          = 6;
  localparam logic [5:0]  LEVEL_FULL       = 6'd50;
  localparam logic [5:0]  LEVEL_ZERO       = 6'd0;
  localparam int          OUT_SEC_W        = 20;
  localparam logic [19:0] OUT_SEC_MAX      = 20'hFFFFF;
  localparam logic [19:0] DAY_SECONDS      = 20'd86400;
  localparam logic [8:0]  PUMP_SEC_PER_LVL = 9'd6;
  localparam logic [7:0]  SAVED_DUTY_RST   = 8'd255;

  typedef struct packed {
    logic       kind;
    logic [7:0] delay_knob;
    logic [7:0] pump_knob;
  } item_t;

  typedef struct packed {
    logic [7:0]  pwm_duty;
    logic        pump_running;
    logic        adjusting;
    logic        save_request;
    logic [7:0]  save_value;
    logic [19:0] elapsed_seconds;
  } result_t;

  // (50 * raw) / 255, division by 255 via add-and-shift (exact below 65025)
  function automatic logic [LEVEL_W-1:0] knob_level(input logic [7:0] raw);
    logic [13:0] x;
    logic [14:0] y;
    x = 14'(raw) * 14'd50;
    y = 15'(x) + 15'(x >> 8) + 15'd1;
    return y[13:8];
  endfunction

  // whole days of off delay: floor(7 * lv / 50), plus one below full scale
  function automatic logic [2:0] delay_days(input logic [LEVEL_W-1:0] lv);
    logic [8:0] p;
    logic [2:0] days;
    p    = 9'(lv) * 9'd7;
    days = 3'd0;
    for (int q = 1; q < 8; q++) begin
      if (p >= 9'(50 * q)) days = 3'(q);
    end
    if (lv != LEVEL_FULL) days = days + 3'd1;
    return days;
  endfunction

  // on period in seconds: 300 * lv / 50
  function automatic logic [8:0] on_seconds(input logic [LEVEL_W-1:0] lv);
    return 9'(lv) * PUMP_SEC_PER_LVL;
  endfunction

  // adjust duty: 255 * lv / 50 = 5 * lv + lv / 10
  function automatic logic [7:0] adjust_duty(input logic [LEVEL_W-1:0] lv);
    logic [13:0] t;
    t = 14'(lv) * 14'd205;
    return (8'(lv) * 8'd5) + 8'(t[13:11]);
  endfunction

endpackage

[sv/ipt_in_stage.sv]
// ---------------------------------------------------------------------------
// ipt_in_stage - input register
// Holds one accepted word until the core consumes it.
// ---------------------------------------------------------------------------
module ipt_in_stage
  import ipt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  valid,
  output item_t item
);

  // free when empty or being drained this cycle
  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

[sv/ipt_core.sv]
// ---------------------------------------------------------------------------
// ipt_core - timer and pump state
// Counters, phase, adjust mode and duty registers; one step per word.
// ---------------------------------------------------------------------------
module ipt_core
  import ipt_pkg::*;
#(
  parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF,
  parameter int SECONDS_WIDTH    = SECONDS_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t result
);

  localparam int TENTH_W = $clog2(TICKS_PER_SECOND + 1);
  localparam logic [SECONDS_WIDTH-1:0] SEC_MAX = {SECONDS_WIDTH{1'b1}};

  logic [TENTH_W-1:0]       tenth_count, tenth_count_next, tenth_inc;
  logic [SECONDS_WIDTH-1:0] second_count, second_count_next;
  logic                     pump_phase, pump_phase_next;
  logic                     adjust_flag, adjust_flag_next;
  logic [7:0]               saved_duty, saved_duty_next;
  logic [7:0]               trial_duty, trial_duty_next;
  logic [7:0]               applied_duty, applied_duty_next;

  logic [LEVEL_W-1:0] lv_delay, lv_pump;
  logic [19:0]        delay_sec, limit;
  logic [7:0]         cur_duty;
  logic               save_req;
  logic [7:0]         save_val;

  assign lv_delay  = knob_level(item.delay_knob);
  assign lv_pump   = knob_level(item.pump_knob);
  assign delay_sec = 20'(delay_days(lv_delay)) * DAY_SECONDS;
  assign limit     = pump_phase ? 20'(on_seconds(lv_pump)) : delay_sec;
  assign cur_duty  = adjust_duty(lv_pump);
  assign tenth_inc = tenth_count + TENTH_W'(1);

  // next state for one word
  always_comb begin
    tenth_count_next  = tenth_count;
    second_count_next = second_count;
    pump_phase_next   = pump_phase;
    adjust_flag_next  = adjust_flag;
    saved_duty_next   = saved_duty;
    trial_duty_next   = trial_duty;
    applied_duty_next = applied_duty;
    save_req          = 1'b0;
    save_val          = 8'd0;
    if (item.kind == KIND_TICK) begin
      // tick: count tenths, saturating seconds
      if (tenth_inc >= TENTH_W'(TICKS_PER_SECOND)) begin
        tenth_count_next = '0;
        if (second_count != SEC_MAX) second_count_next = second_count + SECONDS_WIDTH'(1);
      end else begin
        tenth_count_next = tenth_inc;
      end
    end else if (!adjust_flag) begin
      // poll in normal mode
      if (lv_delay == LEVEL_ZERO) begin
        adjust_flag_next = 1'b1;
      end else if (SECONDS_WIDTH'(limit) <= second_count) begin
        tenth_count_next  = '0;
        second_count_next = '0;
        pump_phase_next   = ~pump_phase;
        applied_duty_next = pump_phase ? 8'd0 : saved_duty;
      end
    end else begin
      // poll in adjust mode
      trial_duty_next = cur_duty;
      if (cur_duty != trial_duty) applied_duty_next = cur_duty;
      if (lv_delay == LEVEL_FULL) begin
        adjust_flag_next = 1'b0;
        if (cur_duty != 8'd0) begin
          saved_duty_next = cur_duty;
          save_req        = 1'b1;
          save_val        = cur_duty;
        end
        pump_phase_next   = 1'b0;
        applied_duty_next = 8'd0;
        tenth_count_next  = '0;
        second_count_next = '0;
      end
    end
  end

  // result word from the updated state
  always_comb begin
    result.pwm_duty     = applied_duty_next;
    result.pump_running = pump_phase_next && !adjust_flag_next;
    result.adjusting    = adjust_flag_next;
    result.save_request = save_req;
    result.save_value   = save_val;
    if (second_count_next > SECONDS_WIDTH'(OUT_SEC_MAX)) begin
      result.elapsed_seconds = OUT_SEC_MAX;
    end else begin
      result.elapsed_seconds = second_count_next[OUT_SEC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tenth_count  <= '0;
      second_count <= '0;
      pump_phase   <= 1'b0;
      adjust_flag  <= 1'b0;
      saved_duty   <= SAVED_DUTY_RST;
      trial_duty   <= 8'd0;
      applied_duty <= 8'd0;
    end else if (fire) begin
      tenth_count  <= tenth_count_next;
      second_count <= second_count_next;
      pump_phase   <= pump_phase_next;
      adjust_flag  <= adjust_flag_next;
      saved_duty   <= saved_duty_next;
      trial_duty   <= trial_duty_next;
      applied_duty <= applied_duty_next;
    end
  end

endmodule

[sv/ipt_out_stage.sv]
// ---------------------------------------------------------------------------
// ipt_out_stage - result register
// Holds one result word until the sink takes it.
// ---------------------------------------------------------------------------
module ipt_out_stage
  import ipt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  result_t result_in,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result
);

  // room for a new word when empty or being read
  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_in;
    end
  end

endmodule

[sv/interval_pump_timer_controller.sv]
// ---------------------------------------------------------------------------
// interval_pump_timer_controller - watering pump interval timer
// Tick/poll driven off-delay and on-period sequencer with duty adjust mode.
// ---------------------------------------------------------------------------
// One word in, one result word out. A word is taken every cycle while the sink
// keeps up; its result goes from the input register through the single
// state-update step into the result register. Throughput is one word per
// cycle while the sink is not stalling, set by the single-step update of the
// timer and pump state registers; a stalled sink holds the result register
// and then backs up the input register.
module interval_pump_timer_controller
  import ipt_pkg::*;
#(
  parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF,
  parameter int SECONDS_WIDTH    = SECONDS_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // delay_knob[7:0], pump_knob[15:8]
  input  logic        s_tuser,  // kind[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // pwm_duty[7:0], pump_running[8], adjusting[9], save_request[10],
  // save_value[18:11], elapsed_seconds[38:19], zero[39]
  output logic [39:0] m_tdata
);

  item_t   in_item, item;
  result_t core_result, result;
  logic    item_valid, advance, fire;

  assign in_item.kind       = s_tuser;
  assign in_item.delay_knob = s_tdata[7:0];
  assign in_item.pump_knob  = s_tdata[15:8];

  assign fire = item_valid && advance;

  ipt_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .advance  (advance),
    .valid    (item_valid),
    .item     (item)
  );

  ipt_core #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .SECONDS_WIDTH    (SECONDS_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (core_result)
  );

  ipt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .result_in (core_result),
    .advance   (advance),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result)
  );

  // pack result word
  assign m_tdata = {1'b0, result.elapsed_seconds, result.save_value,
                    result.save_request, result.adjusting, result.pump_running,
                    result.pwm_duty};

endmodule

[sv/ipt_checker.sv]
// ---------------------------------------------------------------------------
// ipt_checker - port-level checks for the pump timer
// Output handshake and consistency of the result word flags.
// ---------------------------------------------------------------------------
module ipt_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // output register empties on reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // a store request only leaves adjust mode, in delay phase, with nonzero duty
  a_save: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10] |-> !m_tdata[9] && !m_tdata[8] && m_tdata[18:11] != 8'd0)
    else $error("bad store request");

  // no store value without a request
  a_save_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[10] |-> m_tdata[18:11] == 8'd0)
    else $error("store value without request");

  // delay phase of normal mode drives the pump off
  a_idle_duty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[9] && !m_tdata[8] |-> m_tdata[7:0] == 8'd0)
    else $error("duty nonzero in delay phase");

endmodule

bind interval_pump_timer_controller ipt_checker u_ipt_checker (.*);

[tb/interval_pump_timer_controller_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// interval_pump_timer_controller_tb - self-checking bench for the pump timer
// A directed table runs first: reset state, adjust entry and exit, knob extremes.
// Random tick/poll traffic follows under four idle patterns. Every result word is
// checked field by field against a pinned row or an in-bench model of the timer.
// ---------------------------------------------------------------------------
module interval_pump_timer_controller_tb;
  import ipt_pkg::*;

  localparam int          TICKS        = TICKS_PER_SECOND_DEF;
  localparam int          SEC_W        = SECONDS_WIDTH_DEF;
  localparam int unsigned DAY_SEC      = DAY_SECONDS;
  localparam int unsigned WEEK_SEC     = 7 * DAY_SEC;
  localparam int unsigned PUMP_MAX_SEC = 300;
  localparam int unsigned KNOB_FULL    = 255;
  localparam int unsigned RAND_WORDS   = 500;
  localparam int          QUIET_LIMIT  = 5000;
  localparam int          DRAIN_CYCLES = 8;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    item_t      it;
    logic [7:0] reps;
    logic       pinned;
    result_t    res;
  } plan_row_t;

  // DUT ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // delay_knob[7:0], pump_knob[15:8]
  logic        s_tuser = 1'b0; // kind[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // pwm_duty[7:0], pump_running[8], adjusting[9], save_request[10],
  // save_value[18:11], elapsed_seconds[38:19], zero[39]
  logic [39:0] m_tdata;

  // fixed expectation that travels with the word being offered
  logic        pin_on = 1'b0;
  result_t     pin_res = '0;

  // timer model state
  int               tick_cnt;
  logic [SEC_W-1:0] sec_cnt;
  logic             pump_on;
  logic             adj_mode;
  logic [7:0]       stored_duty;
  logic [7:0]       trial_duty;
  logic [7:0]       out_duty;

  result_t     status_expect_q[$];
  plan_row_t   directed_plan[$];
  idle_mode_e  idle_mode = IDLE_NONE;
  int unsigned words_sent = 0;
  int          quiet_cycles = 0;
  bit          failed = 1'b0;

  interval_pump_timer_controller dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random hold-off for either side of the stream, per idle pattern
  function automatic bit hold_off(input bit sender_side);
    case (idle_mode)
      IDLE_SEND: return sender_side && ($urandom_range(99) < 63);
      IDLE_RECV: return !sender_side && ($urandom_range(99) < 63);
      IDLE_BOTH: return $urandom_range(99) < 8;
      default:   return 1'b0;
    endcase
  endfunction

  // raw 8-bit knob sample to a level of 0..50
  function automatic logic [5:0] knob_to_level(input logic [7:0] raw);
    return 6'((int'(LEVEL_FULL) * int'(raw)) / KNOB_FULL);
  endfunction

  // advance the timer model by one word, return the status it should report
  function automatic result_t pump_timer_step(input item_t it);
    result_t     r;
    logic [5:0]  lv_delay;
    logic [5:0]  lv_pump;
    logic [7:0]  dial;
    int unsigned t;
    int unsigned off_sec;
    int unsigned on_sec;
    int unsigned lim;
    r = '0;
    if (it.kind == KIND_TICK) begin
      tick_cnt++;
      if (tick_cnt >= TICKS) begin
        tick_cnt = 0;
        if (sec_cnt != '1) sec_cnt++;
      end
    end else begin
      lv_delay = knob_to_level(it.delay_knob);
      lv_pump  = knob_to_level(it.pump_knob);
      if (!adj_mode) begin
        if (lv_delay == LEVEL_ZERO) begin
          adj_mode = 1'b1;
        end else begin
          // off delay in whole days, rounded up below full scale
          t       = (WEEK_SEC * int'(lv_delay)) / int'(LEVEL_FULL);
          off_sec = DAY_SEC * (t / DAY_SEC) + ((t < WEEK_SEC) ? DAY_SEC : 0);
          on_sec  = (PUMP_MAX_SEC * int'(lv_pump)) / int'(LEVEL_FULL);
          lim     = pump_on ? on_sec : off_sec;
          if (lim <= sec_cnt) begin
            tick_cnt = 0;
            sec_cnt  = '0;
            pump_on  = !pump_on;
            out_duty = pump_on ? stored_duty : 8'd0;
          end
        end
      end else begin
        dial = 8'((KNOB_FULL * int'(lv_pump)) / int'(LEVEL_FULL));
        if (dial != trial_duty) begin
          trial_duty = dial;
          out_duty   = dial;
        end
        // full delay knob leaves adjust mode, storing a nonzero duty
        if (lv_delay == LEVEL_FULL) begin
          adj_mode = 1'b0;
          if (trial_duty != 8'd0) begin
            stored_duty    = trial_duty;
            r.save_request = 1'b1;
            r.save_value   = stored_duty;
          end
          pump_on  = 1'b0;
          out_duty = 8'd0;
          tick_cnt = 0;
          sec_cnt  = '0;
        end
      end
    end
    r.pwm_duty        = out_duty;
    r.pump_running    = pump_on && !adj_mode;
    r.adjusting       = adj_mode;
    r.elapsed_seconds = (sec_cnt > OUT_SEC_MAX) ? OUT_SEC_MAX : sec_cnt[OUT_SEC_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  // offer one word, with random gaps ahead of it; returns at the accepting edge
  task automatic send_word(input logic kind, input logic [7:0] dk, pk,
                           input logic pin, input result_t res);
    while (hold_off(1'b1)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {pk, dk};
    pin_on   <= pin;
    pin_res  <= res;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(KIND_TICK, 8'($urandom), 8'($urandom), 1'b0, '0);
  endtask

  task automatic send_poll(input logic [7:0] dk, pk);
    send_word(KIND_POLL, dk, pk, 1'b0, '0);
  endtask

  function automatic void add_row(input logic kind, input logic [7:0] dk, pk,
                                  input int reps, input logic pinned,
                                  input result_t res);
    plan_row_t row;
    row.it.kind       = kind;
    row.it.delay_knob = dk;
    row.it.pump_knob  = pk;
    row.reps          = 8'(reps);
    row.pinned        = pinned;
    row.res           = res;
    directed_plan.push_back(row);
  endfunction

  // receiver stalls
  always @(posedge clk) m_tready <= !hold_off(1'b0);

  // model update on accepted input words, check on accepted result words
  always @(posedge clk) begin : scoreboard
    item_t   word;
    result_t want;
    if (rst) begin
      tick_cnt    = 0;
      sec_cnt     = '0;
      pump_on     = 1'b0;
      adj_mode    = 1'b0;
      stored_duty = SAVED_DUTY_RST;
      trial_duty  = 8'd0;
      out_duty    = 8'd0;
    end else begin
      if (s_tvalid && s_tready) begin
        word.kind       = s_tuser;
        word.delay_knob = s_tdata[7:0];
        word.pump_knob  = s_tdata[15:8];
        want = pump_timer_step(word);
        status_expect_q.push_back(pin_on ? pin_res : want);
      end
      if (m_tvalid && m_tready) begin
        if (status_expect_q.size() == 0) begin
          $error("result word %h with no expectation pending", m_tdata);
          failed = 1'b1;
        end else begin
          want = status_expect_q.pop_front();
          check_field("pwm_duty", want.pwm_duty, m_tdata[7:0]);
          check_field("pump_running", want.pump_running, m_tdata[8]);
          check_field("adjusting", want.adjusting, m_tdata[9]);
          check_field("save_request", want.save_request, m_tdata[10]);
          check_field("save_value", want.save_value, m_tdata[18:11]);
          check_field("elapsed_seconds", want.elapsed_seconds, m_tdata[38:19]);
        end
      end
    end
  end

  // watchdog: too long with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t   row;
    int unsigned bound;

    // directed table; pinned status order:
    // {pwm_duty, pump_running, adjusting, save_request, save_value, elapsed}
    add_row(KIND_TICK, 8'd255, 8'd255, 1, 1'b1, '0);   // knobs ignored on a tick
    add_row(KIND_POLL, 8'd255, 8'd255, 1, 1'b1, '0);   // week delay, nothing due
    add_row(KIND_POLL, 8'd5, 8'd0, 1, 1'b1,
            {8'd0, 1'b0, 1'b1, 1'b0, 8'd0, 20'd0});    // zero level: adjust
    add_row(KIND_POLL, 8'd128, 8'd255, 1, 1'b1,
            {8'd255, 1'b0, 1'b1, 1'b0, 8'd0, 20'd0});  // full duty while adjusting
    add_row(KIND_POLL, 8'd128, 8'd0, 1, 1'b0, '0);
    add_row(KIND_POLL, 8'd255, 8'd0, 1, 1'b1, '0);     // leave with zero duty
    add_row(KIND_POLL, 8'd0, 8'd255, 1, 1'b0, '0);
    add_row(KIND_POLL, 8'd250, 8'd255, 1, 1'b0, '0);   // level 49 stays in adjust
    add_row(KIND_POLL, 8'd255, 8'd100, 1, 1'b0, '0);   // leave, store mid duty
    add_row(KIND_TICK, 8'd0, 8'd0, 10, 1'b0, '0);      // exactly one second
    add_row(KIND_POLL, 8'd6, 8'd200, 1, 1'b0, '0);     // lowest nonzero delay level
    add_row(KIND_POLL, 8'd40, 8'd0, 1, 1'b0, '0);      // last one-day level
    add_row(KIND_POLL, 8'd41, 8'd255, 1, 1'b0, '0);    // first two-day level
    add_row(KIND_POLL, 8'd0, 8'd255, 1, 1'b0, '0);     // adjust with seconds running
    add_row(KIND_TICK, 8'd0, 8'd0, 2, 1'b0, '0);
    add_row(KIND_POLL, 8'd255, 8'd255, 1, 1'b1,
            {8'd0, 1'b0, 1'b0, 1'b1, 8'd255, 20'd0});  // leave, store full duty

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      repeat (row.reps)
        send_word(row.it.kind, row.it.delay_knob, row.it.pump_knob, row.pinned, row.res);
    end

    // random traffic: tick bursts, polls, adjust sessions, noise
    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = idle_mode_e'(ph);
      bound = words_sent + RAND_WORDS / 4;
      while (words_sent < bound) begin
        case ($urandom_range(9))
          0, 1, 2, 3: repeat ($urandom_range(1, 25)) send_tick();
          4, 5: send_poll(8'($urandom_range(6, 255)), 8'($urandom));
          6, 7, 8: begin
            send_poll(8'($urandom_range(0, 5)), 8'($urandom));
            repeat ($urandom_range(1, 5)) begin
              if ($urandom_range(1)) send_tick();
              else send_poll(8'($urandom_range(6, 254)), 8'($urandom));
            end
            send_poll(8'd255, ($urandom_range(3) == 0) ? 8'($urandom_range(0, 5))
                                                       : 8'($urandom));
          end
          default: send_poll(8'($urandom), 8'($urandom));
        endcase
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (status_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
